// ----- hw/rtl/rcf_pkg.sv -----
package rcf_pkg;

  // Default sizes of the line store and the tap table.
  localparam int MAX_DIM_DEF  = 512;
  localparam int MAX_TAPS_DEF = 7;

  // Configuration port.
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd3;

  // Item kinds.
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_TAP   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Fixed field widths.
  localparam int PIX_W = 8;
  localparam int POS_W = 9;

  // Quotient bits produced by the serial divider, one per cycle.
  localparam int DIV_STEPS = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic tap_write;
    logic setup;
    logic own;
    logic mac_issue;
    logic clamp;
    logic div_step;
    logic out_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_emit;
    logic tap_item;
    logic border;
    logic size_zero;
    logic mac_last;
    logic tap_pos;
    logic div_last;
  } status_t;

endpackage

// ----- hw/rtl/rcf_item_if.sv -----
interface rcf_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        red_in;
  logic [7:0]        green_in;
  logic [7:0]        blue_in;
  logic [2:0]        tap_row;
  logic [2:0]        tap_col;
  logic signed [7:0] tap_value;

  modport source (output valid, kind, red_in, green_in, blue_in, tap_row, tap_col, tap_value,
                  input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, tap_row, tap_col, tap_value,
                output ready);
endinterface

// ----- hw/rtl/rcf_result_if.sv -----
interface rcf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [8:0] out_row;
  logic [8:0] out_col;
  logic       last_pixel;

  modport source (output valid, red_out, green_out, blue_out, out_row, out_col, last_pixel,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, out_row, out_col, last_pixel,
                output ready);
endinterface

// ----- hw/rtl/rcf_ram.sv -----
module rcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rcf_ctrl.sv -----
module rcf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  rcf_pkg::status_t status,
  output rcf_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_SETUP = 9'b0_0000_0010,
    S_OWN   = 9'b0_0000_0100,
    S_MAC   = 9'b0_0000_1000,
    S_MACW  = 9'b0_0001_0000,
    S_CLAMP = 9'b0_0010_0000,
    S_DIV   = 9'b0_0100_0000,
    S_OUT   = 9'b0_1000_0000,
    S_TAP   = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Sequencing of item acceptance, tap writes and one emitted pixel.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.go_emit) state_next = S_SETUP;
          else if (status.tap_item) state_next = S_TAP;
        end
      end
      S_TAP: begin
        cmd.tap_write = 1'b1;
        state_next = S_IDLE;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (status.border) state_next = S_OWN;
        else if (status.size_zero) state_next = S_CLAMP;
        else state_next = S_MAC;
      end
      S_OWN: begin
        cmd.own = 1'b1;
        state_next = S_OUT;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.mac_last) state_next = S_MACW;
      end
      S_MACW: begin
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_next = status.tap_pos ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/rcf_datapath.sv -----
module rcf_datapath #(
  parameter int MAX_DIM  = rcf_pkg::MAX_DIM_DEF,
  parameter int MAX_TAPS = rcf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcf_pkg::CFG_W-1:0]     cfg_data,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  input  logic [2:0]                    tap_row,
  input  logic [2:0]                    tap_col,
  input  logic signed [7:0]             tap_value,
  input  rcf_pkg::cmd_t                 cmd,
  output rcf_pkg::status_t              status,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out,
  output logic [8:0]                    out_row,
  output logic [8:0]                    out_col,
  output logic                          last_pixel
);

  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int DIMV_W     = $clog2(MAX_DIM + 1);
  localparam int EXT_W      = DIMV_W + 1;
  localparam int STORE_ROWS = 2 * (MAX_TAPS / 2) + 1;
  localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int TS_W       = $clog2(MAX_TAPS + 1);
  localparam int TI_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TA_W       = 2 * TI_W;
  localparam int LIN_W      = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int SUM_W      = $clog2(MAX_TAPS * MAX_TAPS * 128 + 1) + 1;
  localparam int REM_W      = SUM_W - 1;
  localparam int ACC_W      = $clog2(MAX_TAPS * MAX_TAPS * 128 * 255 + 1) + 1;
  localparam int AW         = SLOT_W + DIM_W;
  localparam int PW         = rcf_pkg::PIX_W;
  localparam int DC_W       = $clog2(rcf_pkg::DIV_STEPS);

  // Configuration registers.
  logic [9:0] rows_cfg, cols_cfg;
  logic [2:0] size_cfg;
  logic [7:0] max_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= 10'd512;
      cols_cfg <= 10'd512;
      size_cfg <= 3'd3;
      max_cfg  <= 8'd255;
    end else if (cfg_write) begin
      case (cfg_index)
        rcf_pkg::REG_ROWS: rows_cfg <= cfg_data[9:0];
        rcf_pkg::REG_COLS: cols_cfg <= cfg_data[9:0];
        rcf_pkg::REG_SIZE: size_cfg <= cfg_data[2:0];
        rcf_pkg::REG_MAX:  max_cfg  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions and window size.
  logic [DIMV_W-1:0] rows_eff, cols_eff;
  logic [TS_W-1:0]   size_eff, radius;

  always_comb begin
    if (rows_cfg == '0) rows_eff = DIMV_W'(1);
    else if (32'(rows_cfg) > MAX_DIM) rows_eff = DIMV_W'(MAX_DIM);
    else rows_eff = DIMV_W'(rows_cfg);
    if (cols_cfg == '0) cols_eff = DIMV_W'(1);
    else if (32'(cols_cfg) > MAX_DIM) cols_eff = DIMV_W'(MAX_DIM);
    else cols_eff = DIMV_W'(cols_cfg);
    if (32'(size_cfg) > MAX_TAPS) size_eff = TS_W'(MAX_TAPS);
    else size_eff = TS_W'(size_cfg);
    radius = size_eff >> 1;
  end

  // Position counters.
  logic [DIM_W-1:0]  in_row, in_col, emit_row, emit_col;
  logic [SLOT_W-1:0] in_slot, emit_slot;
  logic [LIN_W-1:0]  in_lin, emit_lin;
  logic              in_done;

  logic in_last, emit_last, pix_take, restart, size_write;
  logic [LIN_W-1:0] delay;

  assign in_last = (DIMV_W'(in_row) == rows_eff - DIMV_W'(1)) &&
                   (DIMV_W'(in_col) == cols_eff - DIMV_W'(1));
  assign emit_last = (DIMV_W'(emit_row) == rows_eff - DIMV_W'(1)) &&
                     (DIMV_W'(emit_col) == cols_eff - DIMV_W'(1));
  assign pix_take   = cmd.accept && (kind == rcf_pkg::KIND_PIXEL) && !in_done;
  assign size_write = cfg_write && (cfg_index == rcf_pkg::REG_SIZE);
  assign restart    = (cfg_write && (cfg_index == rcf_pkg::REG_ROWS ||
                                     cfg_index == rcf_pkg::REG_COLS ||
                                     cfg_index == rcf_pkg::REG_SIZE)) ||
                      (cmd.out_done && emit_last);
  assign delay = LIN_W'(radius) * LIN_W'(cols_eff) + LIN_W'(radius);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (32'(s) == STORE_ROWS - 1) return '0;
    return s + SLOT_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      in_lin    <= '0;
      in_done   <= 1'b0;
      emit_row  <= '0;
      emit_col  <= '0;
      emit_slot <= '0;
      emit_lin  <= '0;
    end else begin
      if (pix_take) begin
        in_lin <= in_lin + LIN_W'(1);
        if (in_last) begin
          in_done <= 1'b1;
        end else if (DIMV_W'(in_col) == cols_eff - DIMV_W'(1)) begin
          in_col  <= '0;
          in_row  <= in_row + DIM_W'(1);
          in_slot <= slot_inc(in_slot);
        end else begin
          in_col <= in_col + DIM_W'(1);
        end
      end
      if (cmd.out_done) begin
        emit_lin <= emit_lin + LIN_W'(1);
        if (DIMV_W'(emit_col) == cols_eff - DIMV_W'(1)) begin
          emit_col  <= '0;
          emit_row  <= emit_row + DIM_W'(1);
          emit_slot <= slot_inc(emit_slot);
        end else begin
          emit_col <= emit_col + DIM_W'(1);
        end
      end
    end
  end

  // Tap table in a small RAM; valid flags make unwritten entries read as zero.
  logic signed [SUM_W-1:0] tap_sum;
  logic [TI_W-1:0]         mi, mj;
  logic [TA_W-1:0]         tap_raddr, tap_addr_q;
  logic [2**TA_W-1:0]      tap_valid;
  logic [7:0]              tap_rdata;
  logic                    tap_vq;
  logic signed [7:0]       tap_cur, tap_val_q;
  logic                    tap_hit, tap_hit_q;

  assign tap_raddr = cmd.mac_issue ? {mi, mj} : {TI_W'(tap_row), TI_W'(tap_col)};
  assign tap_cur   = tap_vq ? $signed(tap_rdata) : 8'sd0;
  assign tap_hit   = (32'(tap_row) < 32'(size_eff)) && (32'(tap_col) < 32'(size_eff));

  rcf_ram #(
    .WIDTH (8),
    .DEPTH (2 ** TA_W)
  ) u_tap_table (
    .clk   (clk),
    .we    (cmd.tap_write && tap_hit_q),
    .waddr (tap_addr_q),
    .wdata (tap_val_q),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  // The tap word is held from acceptance while its old value is read.
  always_ff @(posedge clk) begin
    tap_vq <= tap_valid[tap_raddr];
    if (cmd.accept) begin
      tap_addr_q <= tap_raddr;
      tap_val_q  <= tap_value;
      tap_hit_q  <= tap_hit;
    end
  end

  // A size write empties the table by dropping every valid flag.
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      tap_valid <= '0;
      tap_sum   <= '0;
    end else if (cmd.tap_write && tap_hit_q) begin
      tap_valid[tap_addr_q] <= 1'b1;
      tap_sum <= tap_sum + SUM_W'(tap_val_q) - SUM_W'(tap_cur);
    end
  end

  // Line store.
  logic [AW-1:0]     raddr;
  logic [3*PW-1:0]   rd_data;
  logic [SLOT_W-1:0] win_slot, start_slot;
  logic [DIM_W-1:0]  win_col, col_base;
  logic [SLOT_W:0]   slot_tmp;

  assign raddr = cmd.setup ? {emit_slot, emit_col} : {win_slot, win_col};

  rcf_ram #(
    .WIDTH (3 * PW),
    .DEPTH (2 ** AW)
  ) u_line_store (
    .clk   (clk),
    .we    (pix_take),
    .waddr ({in_slot, in_col}),
    .wdata ({blue_in, green_in, red_in}),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Row slot of the window's top row, modulo the store depth.
  always_comb begin
    slot_tmp = (SLOT_W+1)'(emit_slot) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(radius);
    if (32'(slot_tmp) >= STORE_ROWS) slot_tmp = slot_tmp - (SLOT_W+1)'(STORE_ROWS);
    start_slot = slot_tmp[SLOT_W-1:0];
  end

  // Window scan, one tap per cycle.
  logic [TI_W-1:0]   last_idx;
  logic              pend;

  assign last_idx = TI_W'(size_eff - TS_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.mac_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      mi       <= '0;
      mj       <= '0;
      win_slot <= start_slot;
      win_col  <= emit_col - DIM_W'(radius);
      col_base <= emit_col - DIM_W'(radius);
    end else if (cmd.mac_issue) begin
      if (mj == last_idx) begin
        mj       <= '0;
        mi       <= mi + TI_W'(1);
        win_col  <= col_base;
        win_slot <= slot_inc(win_slot);
      end else begin
        mj      <= mj + TI_W'(1);
        win_col <= win_col + DIM_W'(1);
      end
    end
  end

  // Per-channel accumulate, clamp and serial divide.
  logic signed [ACC_W-1:0] acc [3];
  logic [PW-1:0]           res [3];
  logic [REM_W-1:0]        rem [3];
  logic [DC_W-1:0]         div_cnt;
  logic [REM_W-1:0]        divisor;

  assign divisor = tap_sum[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [16:0] prod;
    logic [REM_W:0]     trial;

    assign prod  = tap_cur * $signed({1'b0, rd_data[PW*c +: PW]});
    assign trial = {rem[c], res[c][PW-1]};

    always_ff @(posedge clk) begin
      if (cmd.setup) begin
        acc[c] <= '0;
      end else if (pend) begin
        acc[c] <= acc[c] + ACC_W'(prod);
      end
      if (cmd.own) begin
        res[c] <= rd_data[PW*c +: PW];
      end else if (cmd.clamp) begin
        rem[c] <= '0;
        if (acc[c] < 0) res[c] <= '0;
        else if (acc[c] > $signed(ACC_W'(max_cfg))) res[c] <= max_cfg;
        else res[c] <= acc[c][PW-1:0];
      end else if (cmd.div_step) begin
        if (trial >= {1'b0, divisor}) begin
          rem[c] <= REM_W'(trial - {1'b0, divisor});
          res[c] <= {res[c][PW-2:0], 1'b1};
        end else begin
          rem[c] <= trial[REM_W-1:0];
          res[c] <= {res[c][PW-2:0], 1'b0};
        end
      end
    end
  end

  // Status to the controller.
  always_comb begin
    status = '0;
    if (kind == rcf_pkg::KIND_PIXEL && !in_done) begin
      status.go_emit = (in_lin - emit_lin) >= delay;
    end else begin
      status.go_emit = (kind == rcf_pkg::KIND_PIXEL || kind == rcf_pkg::KIND_FLUSH) && in_done;
    end
    status.tap_item = (kind == rcf_pkg::KIND_TAP);
    status.border = (EXT_W'(emit_row) < EXT_W'(radius)) ||
                    (EXT_W'(emit_col) < EXT_W'(radius)) ||
                    (EXT_W'(emit_row) + EXT_W'(radius) + EXT_W'(1) > EXT_W'(rows_eff)) ||
                    (EXT_W'(emit_col) + EXT_W'(radius) + EXT_W'(1) > EXT_W'(cols_eff));
    status.size_zero = (size_eff == '0);
    status.mac_last  = (mi == last_idx) && (mj == last_idx);
    status.tap_pos   = (tap_sum > 0);
    status.div_last  = (32'(div_cnt) == rcf_pkg::DIV_STEPS - 1);
  end

  // Result word.
  assign red_out    = res[0];
  assign green_out  = res[1];
  assign blue_out   = res[2];
  assign out_row    = rcf_pkg::POS_W'(emit_row);
  assign out_col    = rcf_pkg::POS_W'(emit_col);
  assign last_pixel = emit_last;

endmodule

// ----- hw/rtl/rgb_convolution_filter_unit.sv -----
// RGB square-window convolution filter.
// The items channel carries pixels in raster order, tap writes and flush ticks;
// the results channel carries one filtered pixel with its row, column and a
// last-pixel mark. Both use valid/ready; a word moves when both are high.
// The configuration port writes rows, columns, filter size and clamp value;
// the user must do so only while the block is idle, which the block does not
// enforce. A size write clears the tap table. A pixel that completes no
// output is stored while the block stays idle; a tap write first reads the
// old coefficient and then stores the new one. A pixel or flush tick that
// completes an output passes a setup state; a border pixel is then read back
// from the line store, while an interior pixel scans its size*size window
// through the single store read port and the per-channel multiply-accumulates,
// waits for the last product, is clamped and, when the tap sum is positive,
// goes through the serial divider. The result word then sits in the output
// register until it is taken; while the receiver stalls no new word is
// accepted. Reset restores the default registers, zeroes the tap table and
// counters and starts a new frame; the line store is not cleared.
module rgb_convolution_filter_unit #(
  parameter int MAX_DIM  = rcf_pkg::MAX_DIM_DEF,
  parameter int MAX_TAPS = rcf_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcf_pkg::CFG_W-1:0]     cfg_data,
  rcf_item_if.sink                      items,
  rcf_result_if.source                  results
);

  rcf_pkg::cmd_t    cmd;
  rcf_pkg::status_t status;

  // Sequencer.
  rcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (items.ready),
    .out_valid (results.valid)
  );

  // Stores, counters and arithmetic.
  rcf_datapath #(
    .MAX_DIM  (MAX_DIM),
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (items.kind),
    .red_in     (items.red_in),
    .green_in   (items.green_in),
    .blue_in    (items.blue_in),
    .tap_row    (items.tap_row),
    .tap_col    (items.tap_col),
    .tap_value  (items.tap_value),
    .cmd        (cmd),
    .status     (status),
    .red_out    (results.red_out),
    .green_out  (results.green_out),
    .blue_out   (results.blue_out),
    .out_row    (results.out_row),
    .out_col    (results.out_col),
    .last_pixel (results.last_pixel)
  );

endmodule

// ----- tb/rgb_convolution_filter_unit_test.sv -----
module rgb_convolution_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = 7;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [2:0]        tap_row;
    logic [2:0]        tap_col;
    logic signed [7:0] tap_value;
  } item_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] row;
    logic [8:0] col;
    logic       last;
  } pixel_word_t;

  // Directed rows: the word to send and, where obvious, the pixel it must yield.
  typedef struct {
    item_word_t  word;
    bit          typed;
    pixel_word_t pixel;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rcf_pkg::CFG_W-1:0] cfg_data = '0;

  rcf_item_if items ();
  rcf_result_if results ();

  rgb_convolution_filter_unit dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .items(items.sink), .results(results.source)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow state of the filter.
  logic [23:0] line_mem [STORE_ROWS][512];
  int          taps [7][7];
  int          taps_total;
  int          in_row, in_col, emit_row, emit_col;
  bit          frame_in_done;
  int          rows_reg, cols_reg, size_reg, clamp_reg;

  pixel_word_t pending_pixels [$];
  int          mismatches = 0;
  int          idle_phase = 0;
  int          words_sent = 0;
  int          stall_cycles = 0;

  function automatic int clip_dim(int v);
    if (v == 0) return 1;
    if (v > 512) return 512;
    return v;
  endfunction

  function automatic int window_size();
    return (size_reg > 7) ? 7 : size_reg;
  endfunction

  function automatic void new_frame();
    in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
    frame_in_done = 0;
  endfunction

  function automatic void reset_shadow();
    foreach (taps[i, j]) taps[i][j] = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    taps_total = 0;
    rows_reg = 512; cols_reg = 512; size_reg = 3; clamp_reg = 255;
    new_frame();
  endfunction

  function automatic void apply_register(logic [rcf_pkg::CFG_IDX_W-1:0] idx,
                                         logic [rcf_pkg::CFG_W-1:0] v);
    case (idx)
      rcf_pkg::REG_ROWS: begin
        rows_reg = v; new_frame();
      end
      rcf_pkg::REG_COLS: begin
        cols_reg = v; new_frame();
      end
      rcf_pkg::REG_SIZE: begin
        size_reg = v[2:0];
        foreach (taps[i, j]) taps[i][j] = 0;
        taps_total = 0;
        new_frame();
      end
      default: begin
        clamp_reg = v[7:0];
      end
    endcase
  endfunction

  // Filtered or passed-through pixel at the emit position; advances the emit counters.
  function automatic pixel_word_t emit_pixel();
    pixel_word_t px;
    int rows, cols, sz, rad, acc;
    logic [23:0] own, nb;
    bit edge_px;
    rows = clip_dim(rows_reg);
    cols = clip_dim(cols_reg);
    sz = window_size();
    rad = sz / 2;
    own = line_mem[emit_row % STORE_ROWS][emit_col];
    edge_px = emit_row < rad || emit_col < rad || emit_row + rad + 1 > rows ||
              emit_col + rad + 1 > cols;
    for (int ch = 0; ch < 3; ch++) begin
      if (edge_px) begin
        acc = (own >> (8 * ch)) & 8'hFF;
      end else begin
        acc = 0;
        for (int i = 0; i < sz; i++)
          for (int j = 0; j < sz; j++) begin
            nb = line_mem[(emit_row - rad + i) % STORE_ROWS][emit_col - rad + j];
            acc += taps[i][j] * int'((nb >> (8 * ch)) & 8'hFF);
          end
        if (acc < 0) acc = 0;
        else if (acc > clamp_reg) acc = clamp_reg;
        if (taps_total > 0) acc = acc / taps_total;
      end
      case (ch)
        0: px.red = acc[7:0];
        1: px.green = acc[7:0];
        default: px.blue = acc[7:0];
      endcase
    end
    px.row = emit_row[8:0];
    px.col = emit_col[8:0];
    px.last = (emit_row == rows - 1) && (emit_col == cols - 1);
    if (px.last) begin
      new_frame();
    end else if (++emit_col >= cols) begin
      emit_col = 0;
      emit_row++;
    end
    return px;
  endfunction

  // Updates the shadow state for one accepted word; returns 1 with a pixel if one is due.
  function automatic bit filter_step(item_word_t w, output pixel_word_t px);
    int rows, cols, rad, lag, in_pos, out_pos;
    int v;
    if (w.kind == rcf_pkg::KIND_TAP) begin
      v = w.tap_value;
      if (w.tap_row < window_size() && w.tap_col < window_size()) begin
        taps_total += v - taps[w.tap_row][w.tap_col];
        taps[w.tap_row][w.tap_col] = v;
      end
      return 0;
    end
    if (w.kind == rcf_pkg::KIND_PIXEL && !frame_in_done) begin
      rows = clip_dim(rows_reg);
      cols = clip_dim(cols_reg);
      rad = window_size() / 2;
      lag = rad * cols + rad;
      in_pos = in_row * cols + in_col;
      out_pos = emit_row * cols + emit_col;
      line_mem[in_row % STORE_ROWS][in_col] = {w.blue, w.green, w.red};
      if (in_row == rows - 1 && in_col == cols - 1) begin
        frame_in_done = 1;
      end else if (++in_col >= cols) begin
        in_col = 0;
        in_row++;
      end
      if (out_pos + lag <= in_pos) begin
        px = emit_pixel();
        return 1;
      end
      return 0;
    end
    if ((w.kind == rcf_pkg::KIND_PIXEL || w.kind == rcf_pkg::KIND_FLUSH) && frame_in_done) begin
      px = emit_pixel();
      return 1;
    end
    return 0;
  endfunction

  function automatic bit sender_rests();
    case (idle_phase)
      0: return $urandom_range(99) < 20;
      1: return $urandom_range(99) < 76;
      default: return 0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (idle_phase)
      0: return $urandom_range(99) < 76;
      1: return $urandom_range(99) < 20;
      default: return 0;
    endcase
  endfunction

  // Sends one word; a typed pixel replaces the predicted one.
  task automatic send_word(item_word_t w, bit typed = 0, pixel_word_t typed_px = '{default: 0});
    pixel_word_t px;
    @(negedge clk);
    while (sender_rests()) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid <= 1'b1;
    items.kind <= w.kind;
    items.red_in <= w.red;
    items.green_in <= w.green;
    items.blue_in <= w.blue;
    items.tap_row <= w.tap_row;
    items.tap_col <= w.tap_col;
    items.tap_value <= w.tap_value;
    do @(posedge clk); while (!items.ready);
    words_sent++;
    if (filter_step(w, px)) pending_pixels.push_back(typed ? typed_px : px);
  endtask

  // Waits until the block is idle so that registers may be written.
  task automatic drain_block();
    @(negedge clk);
    items.valid <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_register(logic [rcf_pkg::CFG_IDX_W-1:0] idx, int v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[rcf_pkg::CFG_W-1:0];
    @(posedge clk);
    apply_register(idx, v[rcf_pkg::CFG_W-1:0]);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic item_word_t pixel_word(int r, int g, int b);
    item_word_t w = '{default: 0};
    w.kind = rcf_pkg::KIND_PIXEL;
    w.red = 8'(r); w.green = 8'(g); w.blue = 8'(b);
    return w;
  endfunction

  function automatic item_word_t tap_word(int tr, int tc, int tv);
    item_word_t w = '{default: 0};
    w.kind = rcf_pkg::KIND_TAP;
    w.tap_row = 3'(tr); w.tap_col = 3'(tc); w.tap_value = 8'(tv);
    return w;
  endfunction

  function automatic item_word_t other_word(logic [1:0] k);
    item_word_t w = '{default: 0};
    w.kind = k;
    w.red = 8'($urandom); w.green = 8'($urandom); w.blue = 8'($urandom);
    w.tap_row = 3'($urandom); w.tap_col = 3'($urandom); w.tap_value = 8'($urandom);
    return w;
  endfunction

  function automatic int random_channel();
    case ($urandom_range(9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic int random_tap();
    if ($urandom_range(9) < 7) return $urandom_range(7) - 2;
    return $urandom_range(255) - 128;
  endfunction

  // Receiver: drive ready at the falling edge, check words at the rising edge.
  always @(negedge clk) results.ready <= rst ? 1'b0 : !receiver_rests();

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: rgb %0d %0d %0d at %0d,%0d last %0d",
                   results.red_out, results.green_out, results.blue_out,
                   results.out_row, results.out_col, results.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (results.red_out !== want.red || results.green_out !== want.green ||
            results.blue_out !== want.blue || results.out_row !== want.row ||
            results.out_col !== want.col || results.last_pixel !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected rgb %0d %0d %0d at %0d,%0d last %0d",
                     want.red, want.green, want.blue, want.row, want.col, want.last);
            $display("          got rgb %0d %0d %0d at %0d,%0d last %0d",
                     results.red_out, results.green_out, results.blue_out,
                     results.out_row, results.out_col, results.last_pixel);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    directed_row_t plan [$];
    int rows, cols, sz, rad, choice;
    items.valid = 1'b0;
    items.kind = rcf_pkg::KIND_PIXEL;
    items.red_in = '0; items.green_in = '0; items.blue_in = '0;
    items.tap_row = '0; items.tap_col = '0; items.tap_value = '0;
    results.ready = 1'b0;
    reset_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on a 2x2 image with a 3x3 window: every pixel is a border pixel.
    write_register(rcf_pkg::REG_ROWS, 2);
    write_register(rcf_pkg::REG_COLS, 2);
    write_register(rcf_pkg::REG_SIZE, 3);
    write_register(rcf_pkg::REG_MAX, 255);
    end_writes();
    plan.push_back('{pixel_word(0, 0, 0), 0, '{default: 0}});
    plan.push_back('{pixel_word(255, 255, 255), 0, '{default: 0}});
    plan.push_back('{pixel_word(1, 2, 3), 0, '{default: 0}});
    plan.push_back('{pixel_word(128, 64, 32), 1, '{0, 0, 0, 0, 0, 0}});
    plan.push_back('{other_word(2'd3), 0, '{default: 0}});
    plan.push_back('{other_word(rcf_pkg::KIND_FLUSH), 1, '{255, 255, 255, 0, 1, 0}});
    // A pixel while draining is dropped and acts as a flush.
    plan.push_back('{pixel_word(9, 9, 9), 1, '{1, 2, 3, 1, 0, 0}});
    plan.push_back('{other_word(rcf_pkg::KIND_FLUSH), 1, '{128, 64, 32, 1, 1, 1}});
    // Idle flush gives nothing; taps outside the window are ignored.
    plan.push_back('{other_word(rcf_pkg::KIND_FLUSH), 0, '{default: 0}});
    plan.push_back('{tap_word(6, 6, -128), 0, '{default: 0}});
    plan.push_back('{tap_word(0, 3, 127), 0, '{default: 0}});
    plan.push_back('{tap_word(0, 0, 127), 0, '{default: 0}});
    plan.push_back('{tap_word(2, 2, -128), 0, '{default: 0}});
    plan.push_back('{tap_word(1, 1, 1), 0, '{default: 0}});
    plan.push_back('{pixel_word(255, 0, 255), 0, '{default: 0}});
    plan.push_back('{pixel_word(0, 255, 0), 0, '{default: 0}});
    plan.push_back('{pixel_word(170, 85, 15), 0, '{default: 0}});
    plan.push_back('{pixel_word(240, 7, 99), 0, '{default: 0}});
    for (int i = 0; i < 3; i++)
      plan.push_back('{other_word(rcf_pkg::KIND_FLUSH), 0, '{default: 0}});
    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].pixel);

    // Random frames, each under its own register setting.
    while (words_sent < 1900) begin
      drain_block();
      if (words_sent > 1260) idle_phase = 2;
      else if (words_sent > 630) idle_phase = 1;
      choice = $urandom_range(19);
      case (choice)
        0: begin
          rows = 512; cols = 1;
        end
        1: begin
          rows = 1; cols = 512;
        end
        2: begin
          rows = 0; cols = $urandom_range(6);
        end
        3: begin
          rows = 1023; cols = 0;
        end
        default: begin
          rows = $urandom_range(1, 9); cols = $urandom_range(1, 11);
        end
      endcase
      write_register(rcf_pkg::REG_SIZE, $urandom_range(7));
      write_register(rcf_pkg::REG_ROWS, rows);
      write_register(rcf_pkg::REG_COLS, cols);
      case ($urandom_range(3))
        0: write_register(rcf_pkg::REG_MAX, 1);
        1: write_register(rcf_pkg::REG_MAX, 255);
        default: write_register(rcf_pkg::REG_MAX, $urandom_range(1, 255));
      endcase
      end_writes();
      sz = window_size();
      rad = sz / 2;
      for (int i = 0; i < sz; i++)
        for (int j = 0; j < sz; j++)
          if ($urandom_range(4) != 0) send_word(tap_word(i, j, random_tap()));
      if ($urandom_range(2) == 0) send_word(tap_word($urandom_range(7), 7, random_tap()));
      rows = clip_dim(rows);
      cols = clip_dim(cols);
      for (int p = 0; p < rows * cols; p++) begin
        send_word(pixel_word(random_channel(), random_channel(), random_channel()));
        case ($urandom_range(29))
          0: send_word(other_word(2'd3));
          1: send_word(other_word(rcf_pkg::KIND_FLUSH));
          2: send_word(tap_word($urandom_range(7), $urandom_range(7), random_tap()));
          default: ;
        endcase
      end
      for (int k = 0; k < rad * cols + rad + 1; k++)
        send_word($urandom_range(4) == 0 ? other_word(rcf_pkg::KIND_PIXEL)
                                         : other_word(rcf_pkg::KIND_FLUSH));
    end

    drain_block();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rcf_pkg.sv
hw/rtl/rcf_item_if.sv
hw/rtl/rcf_result_if.sv
hw/rtl/rcf_ram.sv
hw/rtl/rcf_ctrl.sv
hw/rtl/rcf_datapath.sv
hw/rtl/rgb_convolution_filter_unit.sv
tb/rgb_convolution_filter_unit_test.sv
